>>> hdl/sgbl_pkg.sv
// shared constants and types of the sorted grid bin locator
`default_nettype none
package sgbl_pkg;

    localparam int GRID_DEPTH  = 128;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(GRID_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int PROD_W      = VALUE_WIDTH + IDX_W;
    localparam int STEP_W      = $clog2(IDX_W);

    localparam int IN_DATA_BITS  = IDX_W + 2 * VALUE_WIDTH;
    localparam int IN_TDATA_W    = ((IN_DATA_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = ((IDX_W + 7) / 8) * 8;

    localparam int GV_LSB = IDX_W;
    localparam int QV_LSB = IDX_W + VALUE_WIDTH;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_LAST,
        S_RD_FIRST,
        S_DIV,
        S_FILL_LO,
        S_PROBE,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

>>> hdl/sgbl_div.sv
// spacing guess: registered multiply then restoring divide, one quotient bit a cycle
`default_nettype none
module sgbl_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [sgbl_pkg::VALUE_WIDTH-1:0] i_num,
    input  wire logic [sgbl_pkg::VALUE_WIDTH-1:0] i_den,
    input  wire logic [sgbl_pkg::IDX_W-1:0]     i_nm1,
    output logic                                o_done,
    output logic [sgbl_pkg::IDX_W-1:0]          o_quot
);
    import sgbl_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_cnt;
    logic [PROD_W-1:0]   r_rem;
    logic [PROD_W-2:0]   r_dsh;
    logic [IDX_W-1:0]    r_quot;
    logic                c_fit;

    // divisor starts shifted so the quotient always fits in IDX_W bits
    assign c_fit = (r_rem >= {1'b0, r_dsh});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == STEP_W'(IDX_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= PROD_W'(i_num) * PROD_W'(i_nm1);
            r_dsh  <= {i_den, (IDX_W - 1)'(0)};
            r_quot <= '0;
        end else if (r_busy) begin
            if (c_fit) begin
                r_rem <= r_rem - {1'b0, r_dsh};
            end
            r_quot <= {r_quot[IDX_W-2:0], c_fit};
            r_dsh  <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

>>> hdl/sorted_grid_bin_locator.sv
// sorted grid bin locator: grid memory, search sequencer and result register
//
// Holds an ascending grid of signed Q16.16 points in a 128 x 32 memory and
// returns the bin of the grid that holds a query value.
// Input stream: tuser selects load (0) or lookup (1). A load writes one grid
// point in the cycle it is accepted and gives no result; ready stays high.
// A lookup gives one result transaction: bin index in tdata, below-range flag
// in tuser. i_cfg_we writes grid_count (clamped to 2..128 in use); the user
// must write it only while the block is idle, the block does not enforce it.
// A lookup that hits a range edge needs two reads through the one memory
// port (last point, first point) before its result. Otherwise the steps are
// the reads and the product, the 7 quotient bits, fetching the guessed bin,
// one memory read per probe and the output register; the walk is at most
// grid_count-1 probes. One lookup is worked on at a time; input ready is
// high only while idle, so the next item comes in the cycle after a result load.
// The result sits in an output register, so the next item is taken while
// the receiver stalls; a new result then waits until that register frees.
// Reset is synchronous active low: it clears the sequencer, the output valid
// and sets grid_count to 2. Grid entries are not cleared and must be loaded
// before they are searched.
`default_nettype none
module sorted_grid_bin_locator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // entry_index, grid_value, query_value, zero pad
    input  wire logic [sgbl_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    // func
    input  wire logic                            i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // bin_index, zero pad
    output logic [sgbl_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // below_range
    output logic                                 o_m_axis_tuser,
    input  wire logic                            i_cfg_we,
    input  wire logic [sgbl_pkg::CNT_W-1:0]      i_cfg_wdata
);
    import sgbl_pkg::*;

    logic signed [VALUE_WIDTH-1:0] r_grid [GRID_DEPTH];
    logic signed [VALUE_WIDTH-1:0] r_rd_data;
    logic [IDX_W-1:0]              c_rd_addr;
    logic                          c_mem_we;

    t_state                        r_state, n_state;
    logic [CNT_W-1:0]              r_count;
    logic signed [VALUE_WIDTH-1:0] r_x, n_x;
    logic signed [VALUE_WIDTH-1:0] r_lo, n_lo;
    logic signed [VALUE_WIDTH-1:0] r_hi, n_hi;
    logic [IDX_W-1:0]              r_nm1, n_nm1;
    logic [IDX_W-1:0]              r_g, n_g;
    logic [IDX_W-1:0]              r_bin, n_bin;
    logic                          r_below, n_below;
    logic                          r_dir_down, n_dir_down;
    logic                          r_first, n_first;
    logic                          r_fill_hi, n_fill_hi;
    logic                          r_out_valid, n_out_valid;
    logic [IDX_W-1:0]              r_out_bin;
    logic                          r_out_below;
    logic                          c_out_load;

    logic                          c_s_accept;
    logic [IDX_W-1:0]              c_nm1;
    logic signed [VALUE_WIDTH:0]   c_num_full, c_den_full;
    logic                          c_div_start;
    logic                          w_div_done;
    logic [IDX_W-1:0]              w_div_quot;
    logic signed [VALUE_WIDTH-1:0] c_lo, c_hi;
    logic                          c_down;
    logic [IDX_W-1:0]              c_g_up, c_g_dn;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign c_s_accept      = i_s_axis_tvalid && o_s_axis_tready;

    // active count clamped to 2..GRID_DEPTH, kept as count-1
    always_comb begin
        if (r_count < CNT_W'(2)) begin
            c_nm1 = IDX_W'(1);
        end else if (r_count > CNT_W'(GRID_DEPTH)) begin
            c_nm1 = IDX_W'(GRID_DEPTH - 1);
        end else begin
            c_nm1 = IDX_W'(r_count - CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_mem_we) begin
            r_grid[i_s_axis_tdata[IDX_W-1:0]] <=
                i_s_axis_tdata[GV_LSB +: VALUE_WIDTH];
        end
        r_rd_data <= r_grid[c_rd_addr];
    end

    assign c_num_full = {r_x[VALUE_WIDTH-1], r_x} - {r_rd_data[VALUE_WIDTH-1], r_rd_data};
    assign c_den_full = {r_hi[VALUE_WIDTH-1], r_hi} - {r_rd_data[VALUE_WIDTH-1], r_rd_data};

    sgbl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_div_start),
        .i_num   (c_num_full[VALUE_WIDTH-1:0]),
        .i_den   (c_den_full[VALUE_WIDTH-1:0]),
        .i_nm1   (r_nm1),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // during a probe one bound comes from the memory, the other is held
    assign c_lo   = r_fill_hi ? r_lo : r_rd_data;
    assign c_hi   = r_fill_hi ? r_rd_data : r_hi;
    assign c_down = r_first ? (c_lo > r_x) : r_dir_down;
    assign c_g_up = r_g + IDX_W'(1);
    assign c_g_dn = r_g - IDX_W'(1);

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_nm1       = r_nm1;
        n_g         = r_g;
        n_bin       = r_bin;
        n_below     = r_below;
        n_dir_down  = r_dir_down;
        n_first     = r_first;
        n_fill_hi   = r_fill_hi;
        c_rd_addr   = r_g;
        c_mem_we    = 1'b0;
        c_div_start = 1'b0;
        c_out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                c_rd_addr = c_nm1;
                if (c_s_accept) begin
                    if (i_s_axis_tuser == FUNC_LOAD) begin
                        c_mem_we = 1'b1;
                    end else begin
                        n_x     = i_s_axis_tdata[QV_LSB +: VALUE_WIDTH];
                        n_nm1   = c_nm1;
                        n_state = S_RD_LAST;
                    end
                end
            end
            S_RD_LAST: begin
                n_hi      = r_rd_data;
                c_rd_addr = '0;
                n_state   = S_RD_FIRST;
            end
            S_RD_FIRST: begin
                n_below = 1'b0;
                n_bin   = '0;
                if (r_x >= r_hi) begin
                    n_bin   = r_nm1;
                    n_state = S_DONE;
                end else if (r_x < r_rd_data) begin
                    n_below = 1'b1;
                    n_state = S_DONE;
                end else if (r_x == r_rd_data) begin
                    n_state = S_DONE;
                end else begin
                    c_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    if (w_div_quot > r_nm1 - IDX_W'(1)) begin
                        n_g = r_nm1 - IDX_W'(1);
                    end else begin
                        n_g = w_div_quot;
                    end
                    c_rd_addr = n_g;
                    n_first   = 1'b1;
                    n_state   = S_FILL_LO;
                end
            end
            S_FILL_LO: begin
                n_lo      = r_rd_data;
                c_rd_addr = c_g_up;
                n_fill_hi = 1'b1;
                n_state   = S_PROBE;
            end
            S_PROBE: begin
                n_first    = 1'b0;
                n_dir_down = c_down;
                if (c_lo <= r_x && r_x < c_hi) begin
                    n_bin   = r_g;
                    n_state = S_DONE;
                end else if (c_down) begin
                    if (r_g <= IDX_W'(1)) begin
                        n_bin   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_g       = c_g_dn;
                        n_hi      = c_lo;
                        c_rd_addr = c_g_dn;
                        n_fill_hi = 1'b0;
                    end
                end else begin
                    if (c_g_up >= r_nm1) begin
                        n_bin   = r_nm1;
                        n_state = S_DONE;
                    end else begin
                        n_g       = c_g_up;
                        n_lo      = c_hi;
                        c_rd_addr = c_g_up + IDX_W'(1);
                        n_fill_hi = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    c_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (c_out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= COUNT_RESET;
            r_out_valid <= 1'b0;
            r_first     <= 1'b0;
            r_fill_hi   <= 1'b0;
            r_dir_down  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_first     <= n_first;
            r_fill_hi   <= n_fill_hi;
            r_dir_down  <= n_dir_down;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_nm1   <= n_nm1;
        r_g     <= n_g;
        r_bin   <= n_bin;
        r_below <= n_below;
        if (c_out_load) begin
            r_out_bin   <= r_bin;
            r_out_below <= r_below;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_out_bin);
    assign o_m_axis_tuser  = r_out_below;

endmodule
`default_nettype wire

>>> hdl/sgbl_chk.sv
// port-level checks of the sorted grid bin locator, bound to the top level
`default_nettype none
module sgbl_chk (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_s_axis_tvalid,
    input wire logic                            o_s_axis_tready,
    input wire logic [sgbl_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    input wire logic                            i_s_axis_tuser,
    input wire logic                            o_m_axis_tvalid,
    input wire logic                            i_m_axis_tready,
    input wire logic [sgbl_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input wire logic                            o_m_axis_tuser,
    input wire logic                            i_cfg_we,
    input wire logic [sgbl_pkg::CNT_W-1:0]      i_cfg_wdata
);
    import sgbl_pkg::*;

    logic c_unused;
    assign c_unused = ^{i_s_axis_tdata, i_cfg_we, i_cfg_wdata};

    // a stalled result transaction stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // below-range results always report bin zero
    a_below_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[IDX_W-1:0] == '0)
        else $error("below range with nonzero bin");

    // a lookup takes the sequencer out of idle, so input ready is low in the cycle after it is accepted
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == FUNC_LOOKUP
        |=> !o_s_axis_tready)
        else $error("input ready right after a lookup");

    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("output valid or busy after reset");

endmodule

bind sorted_grid_bin_locator sgbl_chk u_sgbl_chk (.*);
`default_nettype wire
